// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/bcfp_pkg.sv =====
`default_nettype none
package bcfp_pkg;

	localparam int FRAME_SPAN_DEF = 300;
	localparam int MAX_CELLS_DEF  = 24;

	localparam logic [7:0] SYNC0 = 8'h55;
	localparam logic [7:0] SYNC1 = 8'hAA;
	localparam logic [7:0] SYNC2 = 8'hEB;
	localparam logic [7:0] SYNC3 = 8'h90;
	localparam logic [2:0] SYNC_LEN = 3'd4;

	// frame offsets
	localparam int OFF_FIRST   = 3;   // offset of the last sync byte
	localparam int OFF_TYPE    = 4;
	localparam int OFF_CELLS   = 6;
	localparam int OFF_PACK    = 118;
	localparam int OFF_CURRENT = 126;
	localparam int OFF_TEMP1   = 130;
	localparam int OFF_TEMP2   = 132;
	localparam int SKIP_TAIL   = 3;

	localparam logic [7:0] FT_RES  = 8'd1;
	localparam logic [7:0] FT_VOLT = 8'd2;
	localparam logic [7:0] FT_INFO = 8'd3;

	localparam logic [1:0] KIND_CELL   = 2'd0;
	localparam logic [1:0] KIND_PACK   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       buffer_end;
	} in_item_t;

	typedef struct packed {
		logic        [1:0]  kind;
		logic        [4:0]  cell_index;
		logic signed [15:0] cell_millivolts;
		logic        [4:0]  cell_count;
		logic        [15:0] pack_millivolts;
		logic signed [15:0] current_milliamps;
		logic        [15:0] temp_first;
		logic        [15:0] temp_second;
		logic               got_res;
		logic               volt_seen;
		logic               info_seen;
		logic               last_result;
	} out_item_t;

	// what one accepted byte asks of the result sequencer
	typedef struct packed {
		logic       volt;   // voltage frame completed
		logic       stat;   // buffer end
		logic [2:0] flags;  // info, volt, res
	} evt_t;

	typedef struct packed {
		logic [15:0] pack;
		logic [15:0] current;
		logic [15:0] temp1;
		logic [15:0] temp2;
	} summary_t;

	function automatic logic [7:0] sync_byte(input logic [1:0] pos);
		logic [7:0] r;
		unique case (pos)
			2'd0: r = SYNC0;
			2'd1: r = SYNC1;
			2'd2: r = SYNC2;
			default: r = SYNC3;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bcfp_cell_ram.sv =====
`default_nettype none
module bcfp_cell_ram #(
	parameter int MAX_CELLS = bcfp_pkg::MAX_CELLS_DEF
) (
	input  wire logic clk,
	input  wire logic we,
	input  wire logic [(MAX_CELLS > 1 ? $clog2(MAX_CELLS) : 1)-1:0] waddr,
	input  wire logic [15:0] wdata,
	input  wire logic re,
	input  wire logic [(MAX_CELLS > 1 ? $clog2(MAX_CELLS) : 1)-1:0] raddr,
	output logic [15:0] rdata
);
	import bcfp_pkg::*;

	logic [15:0] mem [MAX_CELLS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bcfp_scanner.sv =====
`default_nettype none
`include "assert_macros.svh"
module bcfp_scanner #(
	parameter int FRAME_SPAN = bcfp_pkg::FRAME_SPAN_DEF,
	parameter int MAX_CELLS  = bcfp_pkg::MAX_CELLS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic acc,
	input  wire bcfp_pkg::in_item_t item,
	output bcfp_pkg::evt_t evt,
	output bcfp_pkg::summary_t sum,
	output logic [$clog2(MAX_CELLS+1)-1:0] cells_found,
	output logic we,
	output logic [(MAX_CELLS > 1 ? $clog2(MAX_CELLS) : 1)-1:0] waddr,
	output logic [15:0] wdata
);
	import bcfp_pkg::*;

	localparam int OW = $clog2(FRAME_SPAN + SKIP_TAIL + 1);
	localparam int CW = $clog2(MAX_CELLS + 1);
	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

	logic [2:0]    sp_q, sp_d;
	logic [OW-1:0] off_q, off_d;
	logic          inf_q, inf_d;
	logic [7:0]    type_q, type_d;
	logic [7:0]    hold_q, hold_d;
	logic [CW-1:0] cf_q, cf_d;
	logic          stop_q, stop_d;
	logic [2:0]    flags_q, flags_d;
	logic          done_q, done_d;
	summary_t      sum_q, sum_d;

	logic [OW-1:0] off_n;
	logic [OW-1:0] idx_full;
	logic          is_cell;
	logic [15:0]   word;
	logic          volt;

	always_comb begin
		sp_d    = sp_q;
		off_d   = off_q;
		inf_d   = inf_q;
		type_d  = type_q;
		hold_d  = hold_q;
		cf_d    = cf_q;
		stop_d  = stop_q;
		flags_d = flags_q;
		done_d  = done_q;
		sum_d   = sum_q;
		we      = 1'b0;
		volt    = 1'b0;

		// the word completing on this byte starts at the current offset
		off_n    = off_q + 1'b1;
		word     = {item.rx_byte, hold_q};
		idx_full = (off_q - OW'(OFF_CELLS)) >> 1;
		is_cell  = (off_q >= OW'(OFF_CELLS)) && (idx_full < OW'(MAX_CELLS));

		if (!done_q) begin
			if (!inf_q) begin
				if (item.rx_byte == sync_byte(sp_q[1:0])) begin
					sp_d = sp_q + 3'd1;
				end else begin
					sp_d = (item.rx_byte == SYNC0) ? 3'd1 : 3'd0;
				end
				if (sp_d == SYNC_LEN) begin
					sp_d   = 3'd0;
					inf_d  = 1'b1;
					off_d  = OW'(OFF_FIRST);
					cf_d   = '0;
					stop_d = 1'b0;
				end
			end else begin
				off_d = off_n;
				if (off_n == OW'(OFF_TYPE)) begin
					type_d = item.rx_byte;
				end
				if (!off_n[0]) begin
					hold_d = item.rx_byte;
				end else begin
					priority if (is_cell) begin
						if (!stop_q) begin
							if (word == 16'd0) begin
								stop_d = 1'b1;
							end else if (idx_full == OW'(cf_q)) begin
								we   = 1'b1;
								cf_d = cf_q + 1'b1;
							end
						end
					end else if (off_q == OW'(OFF_PACK)) begin
						sum_d.pack = word;
					end else if (off_q == OW'(OFF_CURRENT)) begin
						sum_d.current = word;
					end else if (off_q == OW'(OFF_TEMP1)) begin
						sum_d.temp1 = word;
					end else if (off_q == OW'(OFF_TEMP2)) begin
						sum_d.temp2 = word;
					end
				end
				if (off_n == OW'(FRAME_SPAN)) begin
					priority if (type_q == FT_RES) begin
						flags_d[0] = 1'b1;
					end else if (type_q == FT_VOLT) begin
						flags_d[1] = 1'b1;
						volt       = 1'b1;
						done_d     = 1'b1;
					end else if (type_q == FT_INFO) begin
						flags_d[2] = 1'b1;
					end
				end
				if (off_n >= OW'(FRAME_SPAN + SKIP_TAIL)) begin
					inf_d = 1'b0;
					off_d = '0;
				end
			end
		end

		evt.volt  = volt;
		evt.stat  = item.buffer_end;
		evt.flags = flags_d;

		// buffer end: sync, frame, type, flag and done state back to reset; cell count, stop flag and summary kept
		if (item.buffer_end) begin
			sp_d    = 3'd0;
			off_d   = '0;
			inf_d   = 1'b0;
			type_d  = 8'd0;
			hold_d  = 8'd0;
			flags_d = 3'd0;
			done_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q    <= 3'd0;
			off_q   <= '0;
			inf_q   <= 1'b0;
			type_q  <= 8'd0;
			hold_q  <= 8'd0;
			cf_q    <= '0;
			stop_q  <= 1'b0;
			flags_q <= 3'd0;
			done_q  <= 1'b0;
			sum_q   <= '0;
		end else if (acc) begin
			sp_q    <= sp_d;
			off_q   <= off_d;
			inf_q   <= inf_d;
			type_q  <= type_d;
			hold_q  <= hold_d;
			cf_q    <= cf_d;
			stop_q  <= stop_d;
			flags_q <= flags_d;
			done_q  <= done_d;
			sum_q   <= sum_d;
		end
	end

	assign sum         = sum_q;
	assign cells_found = cf_q;
	assign waddr       = idx_full[AW-1:0];
	assign wdata       = word;

	`ASSERT_IMPLY(a_frame_no_sync, inf_q, sp_q == 3'd0)
	`ASSERT_IMPLY(a_hunt_off_zero, !inf_q, off_q == '0)
	`ASSERT_ALWAYS(a_cells_bound, cf_q <= CW'(MAX_CELLS))

endmodule
`default_nettype wire

// ===== hw/rtl/bcfp_emitter.sv =====
`default_nettype none
`include "assert_macros.svh"
module bcfp_emitter #(
	parameter int MAX_CELLS = bcfp_pkg::MAX_CELLS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic acc,
	input  wire bcfp_pkg::evt_t evt,
	input  wire bcfp_pkg::summary_t sum,
	input  wire logic [$clog2(MAX_CELLS+1)-1:0] cells_found,
	output logic re,
	output logic [(MAX_CELLS > 1 ? $clog2(MAX_CELLS) : 1)-1:0] raddr,
	input  wire logic [15:0] rdata,
	output logic busy,
	output logic res_valid,
	input  wire logic res_stall,
	output bcfp_pkg::out_item_t res_data
);
	import bcfp_pkg::*;

	localparam int CW = $clog2(MAX_CELLS + 1);
	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CELL_RD,
		S_CELL_OUT,
		S_SUM,
		S_STAT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic          end_pend_q;
	logic [2:0]    flags_q;
	logic          res_valid_q;
	out_item_t     res_q;

	logic          out_free;
	logic [CW-1:0] cnt_n;
	out_item_t     cell_item, sum_item, stat_item;
	logic          load;
	out_item_t     next_item;

	assign out_free = !res_valid_q || !res_stall;
	assign cnt_n    = cnt_q + 1'b1;

	always_comb begin
		cell_item                 = '0;
		cell_item.kind            = KIND_CELL;
		cell_item.cell_index      = 5'(cnt_q);
		cell_item.cell_millivolts = signed'(rdata);

		sum_item                   = '0;
		sum_item.kind              = KIND_PACK;
		sum_item.cell_count        = 5'(cells_found);
		sum_item.pack_millivolts   = sum.pack;
		sum_item.current_milliamps = signed'(sum.current);
		sum_item.temp_first        = sum.temp1;
		sum_item.temp_second       = sum.temp2;
		sum_item.last_result       = !end_pend_q;

		stat_item             = '0;
		stat_item.kind        = KIND_STATUS;
		stat_item.got_res     = flags_q[0];
		stat_item.volt_seen   = flags_q[1];
		stat_item.info_seen   = flags_q[2];
		stat_item.last_result = 1'b1;

		load      = 1'b0;
		next_item = stat_item;
		unique case (state_q)
			S_CELL_OUT: begin
				load      = out_free;
				next_item = cell_item;
			end
			S_SUM: begin
				load      = out_free;
				next_item = sum_item;
			end
			S_STAT: begin
				load      = out_free;
			end
			default: load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			end_pend_q  <= 1'b0;
			flags_q     <= 3'd0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
				res_q       <= next_item;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						end_pend_q <= evt.stat;
						flags_q    <= evt.flags;
						cnt_q      <= '0;
						if (evt.volt) begin
							state_q <= (cells_found != '0) ? S_CELL_RD : S_SUM;
						end else if (evt.stat) begin
							state_q <= S_STAT;
						end
					end
				end
				S_CELL_RD: begin
					state_q <= S_CELL_OUT;
				end
				S_CELL_OUT: begin
					if (out_free) begin
						cnt_q   <= cnt_n;
						state_q <= (cnt_n == cells_found) ? S_SUM : S_CELL_RD;
					end
				end
				S_SUM: begin
					if (out_free) begin
						state_q <= end_pend_q ? S_STAT : S_IDLE;
					end
				end
				S_STAT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign re        = (state_q == S_CELL_RD);
	assign raddr     = cnt_q[AW-1:0];
	assign busy      = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	`ASSERT_IMPLY(a_read_in_range, state_q == S_CELL_RD, cnt_q < cells_found)
	`ASSERT_IMPLY(a_out_after_read, state_q == S_CELL_OUT, $past(state_q) == S_CELL_RD || $past(state_q) == S_CELL_OUT)

endmodule
`default_nettype wire

// ===== hw/rtl/bms_cell_frame_parser_core.sv =====
// Bytes that end no voltage frame and no buffer are taken one per cycle while busy is
// low. A buffer-end byte holds the input in S_STAT, which registers its status item.
// A byte that closes a voltage frame holds it in S_CELL_RD and S_CELL_OUT per cell,
// S_SUM (+S_STAT on buffer end): each cell is a read of the cell RAM's one registered
// port. Output stalls lengthen these. Reset clears all control state; the cell RAM is
// not cleared, only cells written in the current frame are ever read.
`default_nettype none
module bms_cell_frame_parser_core #(
	parameter int FRAME_SPAN = bcfp_pkg::FRAME_SPAN_DEF,
	parameter int MAX_CELLS  = bcfp_pkg::MAX_CELLS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic byte_valid,
	output logic byte_stall,
	input  wire bcfp_pkg::in_item_t byte_data,
	output logic res_valid,
	input  wire logic res_stall,
	output bcfp_pkg::out_item_t res_data
);
	import bcfp_pkg::*;

	localparam int CW = $clog2(MAX_CELLS + 1);
	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

	logic          acc;
	logic          busy;
	evt_t          evt;
	summary_t      sum;
	logic [CW-1:0] cells_found;
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [15:0]   wdata, rdata;

	assign byte_stall = busy;
	assign acc        = byte_valid && !busy;

	bcfp_scanner #(
		.FRAME_SPAN(FRAME_SPAN),
		.MAX_CELLS (MAX_CELLS)
	) u_scanner (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.item       (byte_data),
		.evt        (evt),
		.sum        (sum),
		.cells_found(cells_found),
		.we         (we),
		.waddr      (waddr),
		.wdata      (wdata)
	);

	bcfp_cell_ram #(
		.MAX_CELLS(MAX_CELLS)
	) u_cell_ram (
		.clk  (clk),
		.we   (we && acc),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	bcfp_emitter #(
		.MAX_CELLS(MAX_CELLS)
	) u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.evt        (evt),
		.sum        (sum),
		.cells_found(cells_found),
		.re         (re),
		.raddr      (raddr),
		.rdata      (rdata),
		.busy       (busy),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data)
	);

endmodule
`default_nettype wire
